>>> rtl/rcbi_pkg.sv
// Shared types and constants of the ray versus cell box intersection block.
package rcbi_pkg;

   localparam int COORD_W   = 32;
   localparam int BND_W     = 34;               // box bounds, exact
   localparam int QUO_W     = 33;               // quotient magnitude bits per lane
   localparam int LANE_LAT  = QUO_W + 4;        // setup, magnitude, range check, steps, sign
   localparam int MERGE_LAT = 4;
   localparam int RSP_LAT   = LANE_LAT + MERGE_LAT + 1;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 8;
   localparam int AXES      = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MARGIN     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_TOLERANCE = 8'd1;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] direction_x;
      logic signed [COORD_W-1:0] direction_y;
      logic signed [COORD_W-1:0] direction_z;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic                      active;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } rsp_type;

   // what one axis lane hands to the merge stage
   typedef struct packed {
      logic signed [COORD_W-1:0] t;
      logic                      middle;
      logic signed [BND_W-1:0]   cand;
      logic signed [BND_W-1:0]   lo;
      logic signed [BND_W-1:0]   hi;
      logic signed [COORD_W-1:0] o;
      logic signed [COORD_W-1:0] d;
   } lane_out_type;

endpackage

>>> rtl/ray_cell_box_intersection_top.sv
// Top level of the ray versus cell box intersection block.
//
// Usage:
//  - Request channel: drive req_item and pulse start. A beat is taken at every
//    clock edge where start is high and busy is low; busy is high only while
//    reset is held, so a new ray can enter on every cycle while earlier ones
//    are still in flight.
//  - Result channel: rsp_valid strobes for one cycle with rsp_item, in
//    request order, after the input register, lane stages and merge M1 to M4.
//    There is no backpressure; the receiver must take it.
//  - CSR channel: csr_ready is always high. Index 0 writes box_margin, index 1
//    writes edge_tolerance, other indexes are dropped. Write only while idle.
//  - Throughput: one ray per clock. The per-axis divider resolves one
//    quotient bit per stage (33 stages).
//  - Datapath: three axis lanes run in parallel (class, distance divide), then
//    a merge pipe picks the hit plane, multiplies out the hit point and checks
//    it against the box.
//  - Reset: synchronous, clears all valid flags in flight and sets both CSRs
//    to 1. No clearing pass; the block takes beats in the first cycle after.
module ray_cell_box_intersection_top #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  rcbi_pkg::req_type                  req_item,
   output logic                               rsp_valid,
   output rcbi_pkg::rsp_type                  rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rcbi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcbi_pkg::CFG_W-1:0]         csr_data
);
   import rcbi_pkg::*;

   // CSRs
   logic [CFG_W-1:0] box_margin_ff, edge_tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_margin_ff <= CFG_W'(1);
         edge_tol_ff   <= CFG_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BOX_MARGIN:     box_margin_ff <= csr_data;
            CSR_EDGE_TOLERANCE: edge_tol_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // input register; no beat is taken while reset is held
   assign busy = reset;

   req_type req_ff;
   logic    in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      req_ff <= req_item;
   end

   // axis lanes
   lane_out_type lane_out [0:AXES-1];

   rcbi_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_x (
      .clock      (clock),
      .origin     (req_ff.origin_x),
      .direction  (req_ff.direction_x),
      .center     (req_ff.center_x),
      .box_margin (box_margin_ff),
      .lane_out   (lane_out[0])
   );

   rcbi_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_y (
      .clock      (clock),
      .origin     (req_ff.origin_y),
      .direction  (req_ff.direction_y),
      .center     (req_ff.center_y),
      .box_margin (box_margin_ff),
      .lane_out   (lane_out[1])
   );

   rcbi_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_z (
      .clock      (clock),
      .origin     (req_ff.origin_z),
      .direction  (req_ff.direction_z),
      .center     (req_ff.center_z),
      .box_margin (box_margin_ff),
      .lane_out   (lane_out[2])
   );

   // beat valid and active flag ride alongside the lanes
   logic valid_line_ff  [0:LANE_LAT-1];
   logic active_line_ff [0:LANE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) valid_line_ff[i] <= 1'b0;
      end else begin
         valid_line_ff[0] <= in_valid_ff;
         for (int i = 1; i < LANE_LAT; i++) valid_line_ff[i] <= valid_line_ff[i-1];
      end
      active_line_ff[0] <= req_ff.active;
      for (int i = 1; i < LANE_LAT; i++) active_line_ff[i] <= active_line_ff[i-1];
   end

   rcbi_merge #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_merge (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (valid_line_ff[LANE_LAT-1]),
      .in_active      (active_line_ff[LANE_LAT-1]),
      .lane_in        (lane_out),
      .edge_tolerance (edge_tol_ff),
      .out_valid      (rsp_valid),
      .out_item       (rsp_item)
   );

endmodule

>>> rtl/rcbi_lane.sv
// One axis lane: slab classification and pipelined candidate distance division.
module rcbi_lane #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic signed [rcbi_pkg::COORD_W-1:0]   origin,
   input  logic signed [rcbi_pkg::COORD_W-1:0]   direction,
   input  logic signed [rcbi_pkg::COORD_W-1:0]   center,
   input  logic        [rcbi_pkg::CFG_W-1:0]     box_margin,
   output rcbi_pkg::lane_out_type                lane_out
);
   import rcbi_pkg::*;

   localparam int F      = COORD_FRAC_BITS;
   localparam int HALF_W = ((F > CFG_W) ? F : CFG_W) + 1;
   localparam int MAG_W  = BND_W;
   localparam int NUM_W  = MAG_W + F;
   localparam int DSH_W  = COORD_W + QUO_W;
   localparam int CMP_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;

   typedef struct packed {
      logic                      middle;
      logic                      dzero;
      logic                      neg;
      logic                      ovf;
      logic signed [BND_W-1:0]   cand;
      logic signed [BND_W-1:0]   lo;
      logic signed [BND_W-1:0]   hi;
      logic signed [COORD_W-1:0] o;
      logic signed [COORD_W-1:0] d;
   } side_type;

   // stage 1: bounds and class
   logic        [HALF_W-1:0]  half;
   logic signed [BND_W-1:0]   c_ext, o_ext, lo, hi, cand;
   logic                      below, above;
   logic signed [BND_W:0]     diff;
   logic signed [BND_W:0]     diff_ff;
   side_type                  s1_ff;

   assign half  = (HALF_W'(1) << (F - 1)) + HALF_W'(box_margin);
   assign c_ext = {{(BND_W-COORD_W){center[COORD_W-1]}}, center};
   assign o_ext = {{(BND_W-COORD_W){origin[COORD_W-1]}}, origin};
   assign lo    = c_ext - {{(BND_W-HALF_W){1'b0}}, half};
   assign hi    = c_ext + {{(BND_W-HALF_W){1'b0}}, half};
   assign below = o_ext < lo;
   assign above = !below && (o_ext > hi);
   assign cand  = below ? lo : (above ? hi : '0);
   assign diff  = {cand[BND_W-1], cand} - {o_ext[BND_W-1], o_ext};

   always_ff @(posedge clock) begin
      diff_ff      <= diff;
      s1_ff.middle <= !below && !above;
      s1_ff.dzero  <= (direction == '0);
      s1_ff.neg    <= above ^ direction[COORD_W-1];
      s1_ff.ovf    <= 1'b0;
      s1_ff.cand   <= cand;
      s1_ff.lo     <= lo;
      s1_ff.hi     <= hi;
      s1_ff.o      <= origin;
      s1_ff.d      <= direction;
   end

   // stage 2: magnitudes
   logic [BND_W:0]     diff_abs;
   logic [NUM_W-1:0]   num_ff;
   logic [COORD_W-1:0] dmag_s2_ff;
   side_type           s2_ff;

   assign diff_abs = diff_ff[BND_W] ? (~diff_ff + 1'b1) : diff_ff;

   always_ff @(posedge clock) begin
      num_ff     <= {diff_abs[MAG_W-1:0], {F{1'b0}}};
      dmag_s2_ff <= s1_ff.d[COORD_W-1] ? (~s1_ff.d + 1'b1) : s1_ff.d;
      s2_ff      <= s1_ff;
   end

   // stage 3: quotient range check, then one quotient bit per stage
   logic [NUM_W-1:0]   rem_ff  [0:QUO_W];
   logic [QUO_W-1:0]   q_ff    [0:QUO_W];
   logic [COORD_W-1:0] dmag_ff [0:QUO_W];
   side_type           side_ff [0:QUO_W];
   side_type           s3_in;

   always_comb begin
      s3_in     = s2_ff;
      s3_in.ovf = CMP_W'(num_ff) >= (CMP_W'(dmag_s2_ff) << QUO_W);
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= num_ff;
      q_ff[0]    <= '0;
      dmag_ff[0] <= dmag_s2_ff;
      side_ff[0] <= s3_in;
   end

   genvar k;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_step
         logic [CMP_W-1:0] trial;
         logic [CMP_W-1:0] rem_ext;
         logic             ge;
         assign trial   = CMP_W'(dmag_ff[k]) << (QUO_W - 1 - k);
         assign rem_ext = CMP_W'(rem_ff[k]);
         assign ge      = rem_ext >= trial;
         always_ff @(posedge clock) begin
            rem_ff[k+1]  <= ge ? NUM_W'(rem_ext - trial) : rem_ff[k];
            q_ff[k+1]    <= {q_ff[k][QUO_W-2:0], ge};
            dmag_ff[k+1] <= dmag_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   endgenerate

   // final stage: sign, saturation, no-candidate value
   logic [QUO_W-1:0]   q;
   side_type           sf;
   logic [COORD_W-1:0] t_in;
   lane_out_type       lane_out_ff;

   assign q  = q_ff[QUO_W];
   assign sf = side_ff[QUO_W];

   always_comb begin
      if (sf.middle || sf.dzero) begin
         t_in = COORD_W'(0) - (COORD_W'(1) << F);
      end else if (sf.neg) begin
         if (sf.ovf || q > (QUO_W'(1) << (COORD_W - 1)))
            t_in = {1'b1, {(COORD_W-1){1'b0}}};
         else
            t_in = COORD_W'(0) - q[COORD_W-1:0];
      end else begin
         if (sf.ovf || q[QUO_W-1:COORD_W-1] != '0)
            t_in = {1'b0, {(COORD_W-1){1'b1}}};
         else
            t_in = q[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      lane_out_ff.t      <= t_in;
      lane_out_ff.middle <= sf.middle;
      lane_out_ff.cand   <= sf.cand;
      lane_out_ff.lo     <= sf.lo;
      lane_out_ff.hi     <= sf.hi;
      lane_out_ff.o      <= sf.o;
      lane_out_ff.d      <= sf.d;
   end

   assign lane_out = lane_out_ff;

endmodule

>>> rtl/rcbi_merge.sv
// Merge stage: picks the hit plane, forms the hit point and checks it against the box.
module rcbi_merge #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic                               in_active,
   input  rcbi_pkg::lane_out_type             lane_in [0:rcbi_pkg::AXES-1],
   input  logic [rcbi_pkg::CFG_W-1:0]         edge_tolerance,
   output logic                               out_valid,
   output rcbi_pkg::rsp_type                  out_item
);
   import rcbi_pkg::*;

   localparam int F     = COORD_FRAC_BITS;
   localparam int PROD_W = 2 * COORD_W;
   localparam int PT_W  = PROD_W + 1;
   localparam int TOL_W = BND_W + 1;

   // M1: largest candidate, lowest axis on ties
   logic signed [COORD_W-1:0] best_in;
   logic [1:0]                plane_in;

   always_comb begin
      best_in  = lane_in[0].t;
      plane_in = 2'd0;
      if (lane_in[1].t > best_in) begin
         best_in  = lane_in[1].t;
         plane_in = 2'd1;
      end
      if (lane_in[2].t > best_in) begin
         best_in  = lane_in[2].t;
         plane_in = 2'd2;
      end
   end

   logic                      m1_valid_ff, m1_active_ff, m1_inside_ff;
   logic signed [COORD_W-1:0] best_ff;
   logic [1:0]                m1_plane_ff;
   lane_out_type              m1_lane_ff [0:AXES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= in_valid;
      end
      m1_active_ff <= in_active;
      m1_inside_ff <= lane_in[0].middle && lane_in[1].middle && lane_in[2].middle;
      best_ff      <= best_in;
      m1_plane_ff  <= plane_in;
      m1_lane_ff   <= lane_in;
   end

   // M2: products and widened bounds
   logic                      m2_valid_ff, m2_active_ff, m2_inside_ff, m2_front_ff;
   logic [1:0]                m2_plane_ff;
   logic signed [PROD_W-1:0]  prod_ff   [0:AXES-1];
   logic signed [TOL_W-1:0]   lo_tol_ff [0:AXES-1];
   logic signed [TOL_W-1:0]   hi_tol_ff [0:AXES-1];
   lane_out_type              m2_lane_ff [0:AXES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else begin
         m2_valid_ff <= m1_valid_ff;
      end
      m2_active_ff <= m1_active_ff;
      m2_inside_ff <= m1_inside_ff;
      m2_front_ff  <= !best_ff[COORD_W-1];
      m2_plane_ff  <= m1_plane_ff;
      m2_lane_ff   <= m1_lane_ff;
      for (int i = 0; i < AXES; i++) begin
         prod_ff[i]   <= best_ff * m1_lane_ff[i].d;
         lo_tol_ff[i] <= {m1_lane_ff[i].lo[BND_W-1], m1_lane_ff[i].lo}
                         - TOL_W'(edge_tolerance);
         hi_tol_ff[i] <= {m1_lane_ff[i].hi[BND_W-1], m1_lane_ff[i].hi}
                         + TOL_W'(edge_tolerance);
      end
   end

   // M3: hit point
   logic                      m3_valid_ff, m3_active_ff, m3_inside_ff, m3_front_ff;
   logic [1:0]                m3_plane_ff;
   logic signed [PT_W-1:0]    pt_ff      [0:AXES-1];
   logic signed [TOL_W-1:0]   m3_lo_ff   [0:AXES-1];
   logic signed [TOL_W-1:0]   m3_hi_ff   [0:AXES-1];
   logic signed [COORD_W-1:0] m3_o_ff    [0:AXES-1];
   logic signed [PROD_W-1:0]  shifted    [0:AXES-1];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         shifted[i] = prod_ff[i] >>> F;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else begin
         m3_valid_ff <= m2_valid_ff;
      end
      m3_active_ff <= m2_active_ff;
      m3_inside_ff <= m2_inside_ff;
      m3_front_ff  <= m2_front_ff;
      m3_plane_ff  <= m2_plane_ff;
      for (int i = 0; i < AXES; i++) begin
         if (m2_plane_ff == 2'(i))
            pt_ff[i] <= {{(PT_W-BND_W){m2_lane_ff[i].cand[BND_W-1]}}, m2_lane_ff[i].cand};
         else
            pt_ff[i] <= {shifted[i][PROD_W-1], shifted[i]}
                        + {{(PT_W-COORD_W){m2_lane_ff[i].o[COORD_W-1]}}, m2_lane_ff[i].o};
         m3_lo_ff[i] <= lo_tol_ff[i];
         m3_hi_ff[i] <= hi_tol_ff[i];
         m3_o_ff[i]  <= m2_lane_ff[i].o;
      end
   end

   // M4: box check, saturation, bypass
   logic                      off_box;
   logic signed [COORD_W-1:0] sat_pt [0:AXES-1];
   rsp_type                   rsp_in;
   rsp_type                   rsp_ff;
   logic                      rsp_valid_ff;

   always_comb begin
      off_box = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         if (m3_plane_ff != 2'(i) && (pt_ff[i] < m3_lo_ff[i] || pt_ff[i] > m3_hi_ff[i]))
            off_box = 1'b1;
         if (pt_ff[i][PT_W-1:COORD_W-1] == '0 || pt_ff[i][PT_W-1:COORD_W-1] == '1)
            sat_pt[i] = pt_ff[i][COORD_W-1:0];
         else if (pt_ff[i][PT_W-1])
            sat_pt[i] = {1'b1, {(COORD_W-1){1'b0}}};
         else
            sat_pt[i] = {1'b0, {(COORD_W-1){1'b1}}};
      end
      if (!m3_active_ff || m3_inside_ff) begin
         rsp_in.hit     = 1'b1;
         rsp_in.point_x = m3_o_ff[0];
         rsp_in.point_y = m3_o_ff[1];
         rsp_in.point_z = m3_o_ff[2];
      end else begin
         rsp_in.hit     = m3_front_ff && !off_box;
         rsp_in.point_x = sat_pt[0];
         rsp_in.point_y = sat_pt[1];
         rsp_in.point_z = sat_pt[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= m3_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_item  = rsp_ff;

endmodule

>>> rtl/rcbi_checker.sv
// Port-level checker for the ray versus cell box intersection block, with its bind.
module rcbi_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input rcbi_pkg::req_type req_item,
   input logic              rsp_valid,
   input rcbi_pkg::rsp_type rsp_item
);
   import rcbi_pkg::*;

   // every accepted beat produces its strobe after the fixed latency
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LAT rsp_valid)
      else $error("missing result strobe");

   // no strobe without a beat taken the latency earlier
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LAT))
      else $error("result strobe without request");

   // an inactive ray comes back as a hit at its own origin
   a_inactive_pass: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_item.active) |-> ##RSP_LAT
         (rsp_item.hit
          && rsp_item.point_x == $past(req_item.origin_x, RSP_LAT)
          && rsp_item.point_y == $past(req_item.origin_y, RSP_LAT)
          && rsp_item.point_z == $past(req_item.origin_z, RSP_LAT)))
      else $error("inactive ray not passed through");

endmodule

bind ray_cell_box_intersection_top rcbi_checker u_rcbi_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
